// File: rtl/bitmap_block_allocator_top_macros.svh
// assertion macros for the allocator control module (bba_ctrl)
// both expect a clock named clock and a synchronous reset named reset in scope
`ifndef BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define BBA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator check failed: same-cycle implication");

// next-cycle implication
`define BBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator check failed: next-cycle implication");

`endif

// File: rtl/bba_pkg.sv
package bba_pkg;

   localparam int ID_W     = 10;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REQUEST = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE    = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_TAKEN = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

   typedef struct packed {
      logic take;
      logic rd_first;
      logic rd_next;
      logic commit;
      logic full;
      logic quick_res;
      logic give;
   } cmd_type;

   typedef struct packed {
      logic quick;
      logic alloc;
      logic free_found;
      logic last;
      logic out_free;
   } sts_type;

endpackage

// File: rtl/bba_if.sv
interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   blk_id;

   modport source (output valid, output func, output blk_id, input ready);
   modport sink (input valid, input func, input blk_id, output ready);
endinterface

interface bba_rsp_if;
   import bba_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     block_index;

   modport source (output valid, output status, output block_index, input ready);
   modport sink (input valid, input status, input block_index, output ready);
endinterface

// File: rtl/bba_ctrl.sv
`include "bitmap_block_allocator_top_macros.svh"

module bba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::sts_type sts,
   output bba_pkg::cmd_type cmd
);
   import bba_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_FETCH = 4'b0010,
      S_CHECK = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            // unused code or id out of range: no bitmap access
            if (sts.quick) begin
               cmd.quick_res = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.rd_first = 1'b1;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!sts.alloc || sts.free_found) begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end else if (sts.last) begin
               cmd.full = 1'b1;
               state_in = S_DONE;
            end else begin
               // keep streaming words, one read a cycle
               cmd.rd_next = 1'b1;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.give = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `BBA_ASSERT_NOW(a_next_read_in_range, cmd.rd_next, (state_ff == S_CHECK) && !sts.last)
   `BBA_ASSERT_NEXT(a_accept_to_fetch, (state_ff == S_IDLE) && req_valid, state_ff == S_FETCH)
   `BBA_ASSERT_NEXT(a_done_holds, (state_ff == S_DONE) && !sts.out_free, state_ff == S_DONE)

endmodule

// File: rtl/bba_datapath.sv
module bba_datapath #(
   parameter int NUM_BLOCKS     = 512,
   parameter int RESERVED_START = 0,
   parameter int RESERVED_COUNT = 1,
   parameter int MAP_WORD_BITS  = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  bba_pkg::cmd_type             cmd,
   output bba_pkg::sts_type             sts,
   input  logic [bba_pkg::FUNC_W-1:0]   req_func,
   input  logic [bba_pkg::ID_W-1:0]     req_blk_id,
   bba_rsp_if.source                    rsp
);
   import bba_pkg::*;

   localparam int DEPTH = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int BW    = $clog2(MAP_WORD_BITS);
   localparam int RSH   = 20;
   localparam int RECIP = ((1 << RSH) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int PW    = ID_W + RSH;

   function automatic logic [MAP_WORD_BITS-1:0] init_word(input logic [AW-1:0] w);
      logic [MAP_WORD_BITS-1:0] v;
      int b;
      v = '0;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         b = int'(w) * MAP_WORD_BITS + j;
         v[j] = (b >= RESERVED_START) && (b < RESERVED_START + RESERVED_COUNT)
                && (b < NUM_BLOCKS);
      end
      return v;
   endfunction

   function automatic logic [MAP_WORD_BITS-1:0] live_mask(input logic [AW-1:0] w);
      logic [MAP_WORD_BITS-1:0] v;
      for (int j = 0; j < MAP_WORD_BITS; j++) begin
         v[j] = (int'(w) * MAP_WORD_BITS + j) < NUM_BLOCKS;
      end
      return v;
   endfunction

   logic [MAP_WORD_BITS-1:0] map_mem [DEPTH];
   logic [DEPTH-1:0]         vld_ff;

   logic [FUNC_W-1:0]        func_ff;
   logic [ID_W-1:0]          id_ff;
   logic [AW-1:0]            idw_ff;
   logic [AW-1:0]            word_ff;
   logic [MAP_WORD_BITS-1:0] rdata_ff;
   logic                     rvld_ff;
   logic [STATUS_W-1:0]      res_status_ff;
   logic [ID_W-1:0]          res_index_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]          rsp_index_ff, rsp_index_in;

   logic [PW-1:0]            prod;
   logic [PW-1:0]            quo;
   logic [ID_W-1:0]          id_rem;
   logic [BW-1:0]            id_bit;
   logic [AW-1:0]            rd_addr;
   logic                     rd_en;
   logic [MAP_WORD_BITS-1:0] cur_word;
   logic [MAP_WORD_BITS-1:0] free_cand;
   logic [BW-1:0]            pos;
   logic [MAP_WORD_BITS-1:0] sel_mask;
   logic [MAP_WORD_BITS-1:0] wdata;
   logic                     bit_set;
   logic                     is_alloc;
   logic                     wr_en;

   // word of block id by reciprocal multiply, exact for every 10-bit id
   assign prod = PW'(req_blk_id) * PW'(RECIP);
   assign quo  = prod >> RSH;

   assign id_rem = id_ff - ID_W'(int'(idw_ff) * MAP_WORD_BITS);
   assign id_bit = id_rem[BW-1:0];

   assign is_alloc = (func_ff == FUNC_ALLOC);
   assign rd_en    = cmd.rd_first || cmd.rd_next;

   always_comb begin
      if (cmd.rd_first) begin
         rd_addr = is_alloc ? '0 : idw_ff;
      end else begin
         rd_addr = word_ff + AW'(1);
      end
   end

   // never-written words read back as their reset contents
   assign cur_word  = rvld_ff ? rdata_ff : init_word(word_ff);
   assign free_cand = ~cur_word & live_mask(word_ff);
   assign bit_set   = cur_word[id_bit];

   always_comb begin
      pos = '0;
      for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
         if (free_cand[j]) begin
            pos = BW'(j);
         end
      end
   end

   assign sel_mask = MAP_WORD_BITS'(1) << (is_alloc ? pos : id_bit);
   assign wdata    = (func_ff == FUNC_RELEASE) ? (cur_word & ~sel_mask)
                                               : (cur_word | sel_mask);
   assign wr_en    = cmd.commit && !((func_ff == FUNC_REQUEST) && bit_set);

   assign sts.quick      = (func_ff == FUNC_NONE) ||
                           (!is_alloc && ({1'b0, id_ff} >= (ID_W+1)'(NUM_BLOCKS)));
   assign sts.alloc      = is_alloc;
   assign sts.free_found = |free_cand;
   assign sts.last       = (word_ff == AW'(DEPTH - 1));
   assign sts.out_free   = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[word_ff] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= map_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[word_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         func_ff <= req_func;
         id_ff   <= req_blk_id;
         idw_ff  <= quo[AW-1:0];
      end
      if (rd_en) begin
         word_ff <= rd_addr;
         rvld_ff <= vld_ff[rd_addr];
      end
      if (cmd.quick_res) begin
         if (func_ff == FUNC_NONE) begin
            res_status_ff <= ST_OK;
            res_index_ff  <= '0;
         end else begin
            res_status_ff <= ST_RANGE;
            res_index_ff  <= id_ff;
         end
      end else if (cmd.full) begin
         res_status_ff <= ST_FULL;
         res_index_ff  <= '0;
      end else if (cmd.commit) begin
         if (is_alloc) begin
            res_status_ff <= ST_OK;
            res_index_ff  <= ID_W'(int'(word_ff) * MAP_WORD_BITS + int'(pos));
         end else begin
            res_status_ff <= ((func_ff == FUNC_REQUEST) && bit_set) ? ST_TAKEN : ST_OK;
            res_index_ff  <= id_ff;
         end
      end
   end

   // output register: holds a finished transaction while the next item runs
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      if (cmd.give) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_index_in  = res_index_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.block_index = rsp_index_ff;

endmodule

// File: rtl/bitmap_block_allocator_top.sv
// First-fit bitmap block allocator. One used/free bit per block is held in a
// single-port bitmap memory of ceil(NUM_BLOCKS / MAP_WORD_BITS) words; blocks
// RESERVED_START onwards (RESERVED_COUNT of them) start out used. func 0 allocates
// the lowest free block, 1 claims a named block, 2 frees a named block; every
// transaction gives exactly one result. One item is worked on at a time: an
// item is taken only while the block is idle, but a finished result may still
// wait in the output register meanwhile. An unused code or an out-of-range id
// is answered without a bitmap access; request and release read the named
// block's word and commit, while allocate reads one bitmap word a cycle
// through the memory's single read port until it finds a free bit or reaches
// the last word. The result then waits until the output register is free, and
// the block returns to idle to take the next item. A per-word valid flag
// stands in for the reset contents, so there is no clearing pass after reset.
module bitmap_block_allocator_top #(
   parameter int NUM_BLOCKS     = 512,
   parameter int RESERVED_START = 0,
   parameter int RESERVED_COUNT = 1,
   parameter int MAP_WORD_BITS  = 32
) (
   input logic       clock,
   input logic       reset,
   bba_req_if.sink   req_chan,
   bba_rsp_if.source rsp_chan
);
   import bba_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    ctl_ready;

   assign req_chan.ready = ctl_ready;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctl_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bba_datapath #(
      .NUM_BLOCKS     (NUM_BLOCKS),
      .RESERVED_START (RESERVED_START),
      .RESERVED_COUNT (RESERVED_COUNT),
      .MAP_WORD_BITS  (MAP_WORD_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_func   (req_chan.func),
      .req_blk_id (req_chan.blk_id),
      .rsp        (rsp_chan)
   );

endmodule
